// File: design/rlt_pkg.sv
// ----------------------------------------------------------------------------
// Run-length line table: shared package
// Widths, default sizes, result status codes, operation codes and the accumulator control word.
// ----------------------------------------------------------------------------
`default_nettype none

package rlt_pkg;

	localparam int MAX_RUNS_DEF = 256;
	localparam int MAX_CODE_DEF = 4096;

	localparam int LINE_W   = 16;
	localparam int OFFSET_W = 12;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// Control of the shared add and compare unit.
	typedef struct packed {
		logic clear;
		logic add;
	} acc_ctl_t;

endpackage

`default_nettype wire

// File: design/rlt_run_mem.sv
// ----------------------------------------------------------------------------
// Run storage
// One write port and one registered read port holding the line and byte count
// of every run.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_run_mem #(
	parameter int DEPTH = rlt_pkg::MAX_RUNS_DEF,
	parameter int AW    = 8,
	parameter int LW    = 13
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [AW-1:0]             wr_addr,
	input  wire logic [rlt_pkg::LINE_W-1:0] wr_line,
	input  wire logic [LW-1:0]             wr_len,
	input  wire logic [AW-1:0]             rd_addr,
	output logic      [rlt_pkg::LINE_W-1:0] rd_line,
	output logic      [LW-1:0]             rd_len
);

	logic [rlt_pkg::LINE_W-1:0] line_mem [DEPTH];
	logic [LW-1:0]              len_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_line;
			len_mem[wr_addr]  <= wr_len;
		end
		rd_line <= line_mem[rd_addr];
		rd_len  <= len_mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: design/rlt_accum.sv
// ----------------------------------------------------------------------------
// Running total unit
// Adds one run length per step to a running total and compares the new total
// against the requested offset.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_accum #(
	parameter int CW = 13,
	parameter int LW = 13
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rlt_pkg::acc_ctl_t            ctl,
	input  wire logic [rlt_pkg::OFFSET_W-1:0] offset,
	input  wire logic [LW-1:0]                len,
	output logic                              hit
);

	logic [CW-1:0] total_q;
	logic [CW-1:0] offset_q;
	logic [CW-1:0] sum;

	assign sum = total_q + CW'(len);
	assign hit = offset_q < sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctl.clear) begin
			total_q <= '0;
		end else if (ctl.add) begin
			total_q <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			offset_q <= CW'(offset);
		end
	end

endmodule

`default_nettype wire

// File: design/rle_line_table.sv
// Append: the result is registered and presented in the cycle after the request
// is taken. Lookup: runs are walked from index 0; the run storage read port
// delivers one run per cycle to the single add and compare unit, and no request
// is taken meanwhile. Out-of-range lookups answer in the cycle after the request.
// Reset clears the run and byte counts; run storage contents are left undefined
// and need no clearing pass.
// ----------------------------------------------------------------------------
// Run-length line table
// Maps code byte offsets to source lines through a table of line runs.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_line_table #(
	parameter int MAX_RUNS = rlt_pkg::MAX_RUNS_DEF,
	parameter int MAX_CODE = rlt_pkg::MAX_CODE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // line_number [15:0], code_offset [27:16]
	input  wire logic        s_axis_tuser,  // op [0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // found_line [15:0]
	output logic      [1:0]  m_axis_tuser   // status [1:0]
);

	localparam int AW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int RUW = $clog2(MAX_RUNS + 1);
	localparam int LW  = $clog2(MAX_CODE + 1);
	localparam int CW  = (LW > rlt_pkg::OFFSET_W) ? LW : rlt_pkg::OFFSET_W;
	localparam logic [LW-1:0]  CODE_LIM = LW'(MAX_CODE);
	localparam logic [RUW-1:0] RUN_LIM  = RUW'(MAX_RUNS);

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t state_q;

	logic [RUW-1:0]             runs_q;
	logic [LW-1:0]              bytes_q;
	logic [rlt_pkg::LINE_W-1:0] last_line_q;
	logic [LW-1:0]              last_len_q;
	logic [AW-1:0]              idx_q;

	logic                       out_valid_q;
	logic [rlt_pkg::LINE_W-1:0] found_q;
	rlt_pkg::status_t           status_q;

	logic [rlt_pkg::LINE_W-1:0]  in_line;
	logic [rlt_pkg::OFFSET_W-1:0] in_offset;
	rlt_pkg::op_t               in_op;
	logic                       take;

	logic                       new_run;
	logic                       code_full;
	logic                       runs_full;
	logic                       app_ok;
	logic                       out_of_range;

	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [LW-1:0]              wr_len;
	logic [AW-1:0]              rd_addr;
	logic [rlt_pkg::LINE_W-1:0] rd_line;
	logic [LW-1:0]              rd_len;

	rlt_pkg::acc_ctl_t          acc_ctl;
	logic                       hit;

	assign in_line   = s_axis_tdata[15:0];
	assign in_offset = s_axis_tdata[27:16];
	assign in_op     = rlt_pkg::op_t'(s_axis_tuser);

	assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
	assign take          = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = found_q;
	assign m_axis_tuser  = status_q;

	// Append decision, taken from the registered counts in the request cycle.
	assign new_run      = (runs_q == '0) || (last_line_q != in_line);
	assign code_full    = bytes_q >= CODE_LIM;
	assign runs_full    = new_run && (runs_q >= RUN_LIM);
	assign app_ok       = !code_full && !runs_full;
	assign out_of_range = CW'(in_offset) >= CW'(bytes_q);

	assign wr_en   = take && (in_op == rlt_pkg::OP_APPEND) && app_ok;
	assign wr_addr = new_run ? runs_q[AW-1:0] : AW'(runs_q - RUW'(1));
	assign wr_len  = new_run ? LW'(1) : LW'(last_len_q + LW'(1));

	// The first read goes out in the request cycle, later ones while walking.
	assign rd_addr = (state_q == S_IDLE) ? '0 : idx_q;

	always_comb begin
		acc_ctl = '0;
		if (state_q == S_IDLE) begin
			acc_ctl.clear = take;
		end else begin
			acc_ctl.add = !hit;
		end
	end

	rlt_run_mem #(
		.DEPTH(MAX_RUNS),
		.AW   (AW),
		.LW   (LW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_line(in_line),
		.wr_len (wr_len),
		.rd_addr(rd_addr),
		.rd_line(rd_line),
		.rd_len (rd_len)
	);

	rlt_accum #(
		.CW(CW),
		.LW(LW)
	) u_acc (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (acc_ctl),
		.offset(in_offset),
		.len   (rd_len),
		.hit   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			runs_q      <= '0;
			bytes_q     <= '0;
			last_line_q <= '0;
			last_len_q  <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			found_q     <= '0;
			status_q    <= rlt_pkg::ST_OK;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (in_op == rlt_pkg::OP_APPEND) begin
							out_valid_q <= 1'b1;
							found_q     <= '0;
							if (app_ok) begin
								status_q   <= rlt_pkg::ST_OK;
								bytes_q    <= bytes_q + LW'(1);
								last_len_q <= wr_len;
								if (new_run) begin
									runs_q      <= runs_q + RUW'(1);
									last_line_q <= in_line;
								end
							end else begin
								status_q <= rlt_pkg::ST_FULL;
							end
						end else if (out_of_range) begin
							out_valid_q <= 1'b1;
							found_q     <= '0;
							status_q    <= rlt_pkg::ST_RANGE;
						end else begin
							idx_q   <= AW'(1);
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					// The offset lies below the byte count, so a run always matches.
					if (hit) begin
						out_valid_q <= 1'b1;
						found_q     <= rd_line;
						status_q    <= rlt_pkg::ST_OK;
						state_q     <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: test/rle_line_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-length line table testbench
// Drives append and lookup requests through the stream ports with random bursts
// and gaps, stalls the result side on a changing pattern with one long hold-off,
// and checks every answer against a shadow copy of the run table.
// ----------------------------------------------------------------------------

module rle_line_table_tb;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 12;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 300;
	localparam int MAX_PRINTS     = 40;

	typedef struct {
		rlt_pkg::op_t    op;
		logic [15:0]     line;
		logic [11:0]     offs;
	} request_t;

	typedef struct {
		logic [15:0]      found_line;
		rlt_pkg::status_t status;
	} answer_t;

	logic         clk        = 1'b0;
	logic         arst_n     = 1'b0;
	logic         req_valid  = 1'b0;
	logic         req_ready;
	logic [31:0]  req_data   = '0;
	rlt_pkg::op_t req_op     = rlt_pkg::OP_APPEND;
	logic         res_valid;
	logic         res_ready  = 1'b0;
	logic [15:0]  res_line;
	logic [1:0]   res_status;

	request_t pending_requests[$];
	answer_t  pending_answers[$];

	// Shadow of the run table, updated as each request is taken.
	logic [15:0] shadow_run_line [rlt_pkg::MAX_RUNS_DEF];
	int          shadow_run_len  [rlt_pkg::MAX_RUNS_DEF];
	int          shadow_runs  = 0;
	int          shadow_bytes = 0;

	int  error_count   = 0;
	int  answers_seen  = 0;
	int  queued_appends = 0;
	int  queued_count  = 0;
	int  idle_cycles   = 0;
	bit  stim_done     = 1'b0;

	// Sender pacing.
	int  gap_left   = 0;
	int  burst_left = 1;

	// Receiver pacing.
	int  stall_mode = 0;
	int  mode_left  = 0;
	int  hold_left  = 0;
	bit  hold_done  = 1'b0;

	always #(CLK_HALF) clk = ~clk;

	rle_line_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (req_valid),
		.s_axis_tready (req_ready),
		.s_axis_tdata  (req_data),
		.s_axis_tuser  (req_op),
		.m_axis_tvalid (res_valid),
		.m_axis_tready (res_ready),
		.m_axis_tdata  (res_line),
		.m_axis_tuser  (res_status)
	);

	function automatic answer_t line_table_step(rlt_pkg::op_t op, logic [15:0] line,
			logic [11:0] offs);
		answer_t ans;
		int      total;
		bit      hit;
		ans.found_line = '0;
		ans.status = rlt_pkg::ST_OK;
		if (op == rlt_pkg::OP_APPEND) begin
			if (shadow_bytes >= rlt_pkg::MAX_CODE_DEF) begin
				ans.status = rlt_pkg::ST_FULL;
			end else if (shadow_runs == 0 || shadow_run_line[shadow_runs - 1] != line) begin
				if (shadow_runs >= rlt_pkg::MAX_RUNS_DEF) begin
					ans.status = rlt_pkg::ST_FULL;
				end else begin
					shadow_run_line[shadow_runs] = line;
					shadow_run_len[shadow_runs] = 1;
					shadow_runs++;
					shadow_bytes++;
				end
			end else begin
				shadow_run_len[shadow_runs - 1]++;
				shadow_bytes++;
			end
		end else begin
			ans.status = rlt_pkg::ST_RANGE;
			total = 0;
			hit = 1'b0;
			for (int i = 0; i < shadow_runs && !hit; i++) begin
				total += shadow_run_len[i];
				if (int'(offs) < total) begin
					ans.found_line = shadow_run_line[i];
					ans.status = rlt_pkg::ST_OK;
					hit = 1'b1;
				end
			end
		end
		return ans;
	endfunction

	task automatic report_mismatch(string msg);
		if (error_count < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_answer();
		answer_t want;
		if (pending_answers.size() == 0) begin
			report_mismatch($sformatf("answer with no request waiting: line %0d status %0d",
				res_line, res_status));
		end else begin
			want = pending_answers.pop_front();
			if (res_line !== want.found_line)
				report_mismatch($sformatf("answer %0d: line %0d, wanted %0d",
					answers_seen, res_line, want.found_line));
			if (res_status !== want.status)
				report_mismatch($sformatf("answer %0d: status %0d, wanted %0d",
					answers_seen, res_status, want.status));
		end
		answers_seen++;
	endtask

	task automatic push_request(rlt_pkg::op_t op, logic [15:0] line, logic [11:0] offs);
		request_t r;
		r.op = op;
		r.line = line;
		r.offs = offs;
		pending_requests.push_back(r);
		queued_count++;
		if (op == rlt_pkg::OP_APPEND && queued_appends < rlt_pkg::MAX_CODE_DEF)
			queued_appends++;
	endtask

	// Request driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		request_t cur;
		answer_t  ans;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			req_op <= rlt_pkg::OP_APPEND;
		end else if (!req_valid || req_ready) begin
			if (req_valid) begin
				ans = line_table_step(req_op, req_data[15:0], req_data[27:16]);
				pending_answers.push_back(ans);
			end
			if (gap_left > 0 || pending_requests.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				req_valid <= 1'b0;
			end else begin
				cur = pending_requests.pop_front();
				req_valid <= 1'b1;
				req_op <= cur.op;
				req_data <= {4'b0000, cur.offs, cur.line};
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					if ($urandom_range(0, 1))
						gap_left = 0;
					else if ($urandom_range(0, 9) == 0)
						gap_left = $urandom_range(17, 60);
					else
						gap_left = $urandom_range(1, 16);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Result monitor with its own stall pattern and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		bit ready_next;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready)
				check_answer();
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(32, 400);
			end else begin
				mode_left--;
			end
			// Holding off here lets the sender fill the block until it refuses requests.
			if (!hold_done && answers_seen >= 150) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (stim_done) begin
				ready_next = 1'b1;
			end else begin
				case (stall_mode)
					0: ready_next = 1'b1;
					1: ready_next = ($urandom_range(0, 3) != 0);
					2: ready_next = ($urandom_range(0, 3) == 0);
					default: ready_next = !res_ready;
				endcase
			end
			res_ready <= ready_next;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
				$display("rle_line_table regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int          pick;
		int          count;
		int          fill;
		int          last_offs;
		logic [15:0] gen_line;
		logic [15:0] last_line;
		logic [15:0] line;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, extreme lines, run extension, boundaries of lookup.
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'd0);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'hFFF);
		push_request(rlt_pkg::OP_APPEND, 16'h0000, 12'($urandom));
		push_request(rlt_pkg::OP_APPEND, 16'h0000, 12'($urandom));
		push_request(rlt_pkg::OP_APPEND, 16'hFFFF, 12'($urandom));
		push_request(rlt_pkg::OP_APPEND, 16'hFFFF, 12'($urandom));
		push_request(rlt_pkg::OP_APPEND, 16'hAAAA, 12'($urandom));
		push_request(rlt_pkg::OP_APPEND, 16'h5555, 12'($urandom));
		push_request(rlt_pkg::OP_APPEND, 16'h5555, 12'($urandom));
		push_request(rlt_pkg::OP_LOOKUP, 16'hFFFF, 12'd0);
		push_request(rlt_pkg::OP_LOOKUP, 16'h0000, 12'd1);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'd2);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'd4);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'd6);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'd7);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'hFFF);
		push_request(rlt_pkg::OP_APPEND, 16'h0000, 12'hFFF);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'd7);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'd8);
		gen_line = 16'h0000;

		// Random: mostly runs of repeated lines and lookups inside the recorded code.
		queued_count = 0;
		while (queued_count < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				case ($urandom_range(0, 7))
					0: line = gen_line;
					1, 2: line = gen_line + 16'd1;
					default: line = 16'($urandom);
				endcase
				count = $urandom_range(1, 6);
				repeat (count) push_request(rlt_pkg::OP_APPEND, line, 12'($urandom));
				gen_line = line;
			end else if (pick < 85) begin
				push_request(rlt_pkg::OP_LOOKUP, 16'($urandom),
					12'($urandom_range(0, (queued_appends < 4095) ? queued_appends + 1 : 4095)));
			end else if (pick < 95) begin
				push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'($urandom_range(0, 4095)));
			end else begin
				line = 16'($urandom);
				push_request(rlt_pkg::OP_APPEND, line, 12'($urandom));
				gen_line = line;
			end
		end

		@(posedge clk);
		while (pending_requests.size() != 0 || req_valid || pending_answers.size() != 0)
			@(posedge clk);

		// Open new runs until the run table is full, then probe the full table.
		last_line = shadow_run_line[shadow_runs - 1];
		fill = rlt_pkg::MAX_RUNS_DEF - shadow_runs;
		last_offs = shadow_bytes + fill;
		for (int i = 0; i < fill; i++) begin
			last_line = last_line + 16'd1;
			push_request(rlt_pkg::OP_APPEND, last_line, 12'($urandom));
		end
		push_request(rlt_pkg::OP_APPEND, last_line, 12'($urandom));
		push_request(rlt_pkg::OP_APPEND, ~last_line, 12'($urandom));
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'(last_offs));
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'hFFF);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'd0);
		push_request(rlt_pkg::OP_LOOKUP, 16'($urandom), 12'($urandom));

		@(posedge clk);
		while (pending_requests.size() != 0 || req_valid || pending_answers.size() != 0)
			@(posedge clk);
		stim_done = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_answers.size() == 0)
			$display("rle_line_table regression: pass");
		else
			$display("rle_line_table regression: fail");
		$finish;
	end

endmodule
